### rtl/core/piece_queue_reserve_stack_defines.svh
// Assertion macros shared by the reserve stack design.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef PIECE_QUEUE_RESERVE_STACK_DEFINES_SVH
`define PIECE_QUEUE_RESERVE_STACK_DEFINES_SVH

`define PQRS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

`define PQRS_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/core/pqrs_pkg.sv
`timescale 1ns / 1ps

package pqrs_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int STACK_DEPTH = 3;
    localparam int ID_BITS     = 16;
    localparam int SWAP_SPAN   = 3;
    localparam int KIND_BITS   = 3;

    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SCNT_W = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W = $clog2(STACK_DEPTH);

    localparam logic [2:0] CMD_FILL    = 3'd0;
    localparam logic [2:0] CMD_PLAY    = 3'd1;
    localparam logic [2:0] CMD_RESERVE = 3'd2;
    localparam logic [2:0] CMD_USE     = 3'd3;
    localparam logic [2:0] CMD_SWAP    = 3'd4;
    localparam logic [2:0] CMD_SWAP3   = 3'd5;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_QUEUE_EMPTY = 3'd1;
    localparam logic [2:0] ST_STACK_FULL  = 3'd2;
    localparam logic [2:0] ST_STACK_EMPTY = 3'd3;
    localparam logic [2:0] ST_TOO_FEW     = 3'd4;
    localparam logic [2:0] ST_QUEUE_FULL  = 3'd5;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [ID_BITS-1:0]   id;
    } t_piece;

    typedef struct packed {
        logic [2:0]           command;
        logic [KIND_BITS-1:0] new_kind;
        logic [ID_BITS-1:0]   new_id;
    } t_in;

    typedef struct packed {
        logic [2:0]           status;
        logic                 piece_valid;
        logic [KIND_BITS-1:0] piece_kind;
        logic [ID_BITS-1:0]   piece_id;
        logic [3:0]           queue_level;
        logic [1:0]           stack_level;
    } t_out;

    typedef struct packed {
        logic shift;
        logic load_new;
        logic load_swap;
    } t_cell_ctl;

    typedef struct packed {
        logic push;
        logic pop;
        logic swap_top;
        logic swap_all;
    } t_stk_ctl;

endpackage

### rtl/core/pqrs_cell.sv
`timescale 1ns / 1ps

module pqrs_cell (
    input  logic               i_clk,
    input  pqrs_pkg::t_cell_ctl i_ctl,
    input  pqrs_pkg::t_piece   i_right,
    input  pqrs_pkg::t_piece   i_new,
    input  pqrs_pkg::t_piece   i_swap,
    output pqrs_pkg::t_piece   o_piece
);
    import pqrs_pkg::*;

    t_piece r_piece;
    t_piece n_piece;

    always_comb begin
        n_piece = r_piece;
        if (i_ctl.load_new) begin
            n_piece = i_new;
        end else if (i_ctl.load_swap) begin
            n_piece = i_swap;
        end else if (i_ctl.shift) begin
            n_piece = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_piece <= n_piece;
    end

    assign o_piece = r_piece;

endmodule

### rtl/core/pqrs_stack.sv
`timescale 1ns / 1ps
`include "piece_queue_reserve_stack_defines.svh"

module pqrs_stack (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  pqrs_pkg::t_stk_ctl                           i_ctl,
    input  pqrs_pkg::t_piece                             i_piece,
    input  pqrs_pkg::t_piece [pqrs_pkg::STACK_DEPTH-1:0] i_trio,
    output pqrs_pkg::t_piece [pqrs_pkg::STACK_DEPTH-1:0] o_ent,
    output pqrs_pkg::t_piece                             o_top,
    output logic [pqrs_pkg::SCNT_W-1:0]                  o_count
);
    import pqrs_pkg::*;

    t_piece              r_ent [STACK_DEPTH];
    logic [SCNT_W-1:0]   r_count;
    logic [SCNT_W-1:0]   n_count;
    logic [SIDX_W-1:0]   top_idx;
    logic [SIDX_W-1:0]   push_idx;

    assign top_idx  = (r_count == '0) ? '0 : SIDX_W'(r_count - SCNT_W'(1));
    assign push_idx = r_count[SIDX_W-1:0];
    assign o_top    = r_ent[top_idx];
    assign o_count  = r_count;

    always_comb begin
        n_count = r_count;
        if (i_ctl.push) begin
            n_count = r_count + SCNT_W'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - SCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_ent[push_idx] <= i_piece;
        end else if (i_ctl.swap_top) begin
            r_ent[top_idx] <= i_piece;
        end else if (i_ctl.swap_all) begin
            for (int k = 0; k < STACK_DEPTH; k++) begin
                r_ent[k] <= i_trio[k];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_ent
            assign o_ent[g] = r_ent[g];
        end
    endgenerate

    `PQRS_ASSERT_ALWAYS(a_one_op, $onehot0({i_ctl.push, i_ctl.pop, i_ctl.swap_top, i_ctl.swap_all}), "stack given more than one operation")
    `PQRS_ASSERT_ALWAYS(a_count_range, r_count <= SCNT_W'(STACK_DEPTH), "stack count beyond depth")
    `PQRS_ASSERT_NEXT(a_push_count, i_ctl.push, r_count == $past(r_count) + SCNT_W'(1), "push did not raise the count")
    `PQRS_ASSERT_NEXT(a_pop_count, i_ctl.pop, r_count == $past(r_count) - SCNT_W'(1), "pop did not lower the count")

endmodule

### rtl/core/piece_queue_reserve_stack.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_in_data  (t_in)
// output    out        o_out_valid / i_out_ready o_out_data (t_out)
//
// Each transaction is executed and its result is registered; one transaction per
// cycle is sustained unless the output stalls, set by the single output register.
// The queue is a row of cells with the front in cell 0; a play shifts the row by one.
// Reset is synchronous and clears the queue and stack counts and the output valid flag.
// A stalled output holds the input off only while the waiting result is not taken.

module piece_queue_reserve_stack (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pqrs_pkg::t_in i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pqrs_pkg::t_out o_out_data
);
    import pqrs_pkg::*;

    logic              in_fire;
    logic              r_out_valid;
    t_out              r_out;
    t_out              n_out;
    logic [QCNT_W-1:0] r_qcount;
    logic [QCNT_W-1:0] n_qcount;
    logic [SCNT_W-1:0] scount;
    logic [SCNT_W-1:0] scount_after;

    logic q_fill;
    logic q_play;
    logic q_swap1;
    logic q_swap3;
    t_stk_ctl stk_ctl;
    t_piece   stk_in;
    t_piece   stk_top;
    t_piece   got;
    logic     got_valid;
    logic [2:0] status;
    t_piece   new_piece;

    t_stk_ctl stk_ctl_q;
    logic     fill_q;
    logic     play_q;
    logic     swap1_q;
    logic     swap3_q;

    t_piece                   cell_q [QUEUE_DEPTH];
    t_piece [STACK_DEPTH-1:0] stk_ent;
    t_piece [STACK_DEPTH-1:0] trio;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign new_piece  = '{kind: i_in_data.new_kind, id: i_in_data.new_id};

    always_comb begin
        q_fill    = 1'b0;
        q_play    = 1'b0;
        q_swap1   = 1'b0;
        q_swap3   = 1'b0;
        stk_ctl   = '0;
        stk_in    = cell_q[0];
        got       = '0;
        got_valid = 1'b0;
        status    = ST_OK;
        case (i_in_data.command)
            CMD_FILL: begin
                if (r_qcount == QCNT_W'(QUEUE_DEPTH)) begin
                    status = ST_QUEUE_FULL;
                end else begin
                    q_fill = 1'b1;
                end
            end
            CMD_PLAY: begin
                if (r_qcount == '0) begin
                    status = ST_QUEUE_EMPTY;
                end else begin
                    q_play    = 1'b1;
                    got       = cell_q[0];
                    got_valid = 1'b1;
                end
            end
            CMD_RESERVE: begin
                if (r_qcount == '0) begin
                    status = ST_QUEUE_EMPTY;
                end else if (scount == SCNT_W'(STACK_DEPTH)) begin
                    status = ST_STACK_FULL;
                end else begin
                    q_play       = 1'b1;
                    stk_ctl.push = 1'b1;
                    got          = cell_q[0];
                    got_valid    = 1'b1;
                end
            end
            CMD_USE: begin
                if (scount == '0) begin
                    status = ST_STACK_EMPTY;
                end else begin
                    stk_ctl.pop = 1'b1;
                    got         = stk_top;
                    got_valid   = 1'b1;
                end
            end
            CMD_SWAP: begin
                if (r_qcount == '0) begin
                    status = ST_QUEUE_EMPTY;
                end else if (scount == '0) begin
                    status = ST_STACK_EMPTY;
                end else begin
                    q_swap1          = 1'b1;
                    stk_ctl.swap_top = 1'b1;
                end
            end
            CMD_SWAP3: begin
                if (scount != SCNT_W'(STACK_DEPTH) || r_qcount < QCNT_W'(SWAP_SPAN)) begin
                    status = ST_TOO_FEW;
                end else begin
                    q_swap3          = 1'b1;
                    stk_ctl.swap_all = 1'b1;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // Only a completed transaction may change the queue or the stack.
    assign stk_ctl_q = in_fire ? stk_ctl : '0;
    assign fill_q    = in_fire && q_fill;
    assign play_q    = in_fire && q_play;
    assign swap1_q   = in_fire && q_swap1;
    assign swap3_q   = in_fire && q_swap3;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_cell_ctl ctl;
            t_piece    right;
            t_piece    swap_src;

            assign ctl.load_new = (fill_q && QCNT_W'(g) == r_qcount)
                || (play_q && QCNT_W'(g) == r_qcount - QCNT_W'(1));
            assign ctl.shift    = play_q && QCNT_W'(g) < r_qcount - QCNT_W'(1);

            if (g < SWAP_SPAN) begin : g_swap
                assign ctl.load_swap = (swap1_q && g == 0) || swap3_q;
                assign swap_src      = swap3_q ? stk_ent[g] : stk_top;
            end else begin : g_noswap
                assign ctl.load_swap = 1'b0;
                assign swap_src      = stk_top;
            end

            if (g < QUEUE_DEPTH - 1) begin : g_mid
                assign right = cell_q[g+1];
            end else begin : g_last
                assign right = '0;
            end

            pqrs_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_right (right),
                .i_new   (new_piece),
                .i_swap  (swap_src),
                .o_piece (cell_q[g])
            );
        end

        for (g = 0; g < STACK_DEPTH; g++) begin : g_trio
            assign trio[g] = cell_q[g];
        end
    endgenerate

    pqrs_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl_q),
        .i_piece (stk_in),
        .i_trio  (trio),
        .o_ent   (stk_ent),
        .o_top   (stk_top),
        .o_count (scount)
    );

    always_comb begin
        n_qcount = r_qcount;
        if (q_fill) begin
            n_qcount = r_qcount + QCNT_W'(1);
        end
        scount_after = scount;
        if (stk_ctl.push) begin
            scount_after = scount + SCNT_W'(1);
        end else if (stk_ctl.pop) begin
            scount_after = scount - SCNT_W'(1);
        end
        n_out.status      = status;
        n_out.piece_valid = got_valid;
        n_out.piece_kind  = got.kind;
        n_out.piece_id    = got.id;
        n_out.queue_level = 4'(n_qcount);
        n_out.stack_level = 2'(scount_after);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_qcount    <= n_qcount;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
